>>> hw/rtl/mrsf_pkg.sv
// ----------------------------------------------------------------------------
// mrsf_pkg
// shared constants for the morton range split finder
// ----------------------------------------------------------------------------
package mrsf_pkg;

    localparam int IDX_W          = 10;
    localparam int FIELD_CODE_W   = 64;
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int CODE_BITS_DEF  = 64;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_FIND = 1'b1;

endpackage

>>> hw/rtl/morton_range_split_finder_core.sv
// ----------------------------------------------------------------------------
// morton_range_split_finder_core
// load item: written into the code table, no result
// query item: reads both end codes, then goes straight to the output register when
//   they are equal or the range is inverted, else runs a binary search over the range;
//   one table read per cycle on the single ram port sets the pace
// one item in flight; a new item is taken once the previous one is handed off
// reset clears the sequencer and output valid; the table is undefined until loaded
// ----------------------------------------------------------------------------
module morton_range_split_finder_core #(
    parameter int TABLE_DEPTH = mrsf_pkg::TABLE_DEPTH_DEF,
    parameter int CODE_BITS   = mrsf_pkg::CODE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    input  logic [mrsf_pkg::IDX_W-1:0]       load_index,
    input  logic [mrsf_pkg::FIELD_CODE_W-1:0] load_code,
    input  logic [mrsf_pkg::IDX_W-1:0]       range_first,
    input  logic [mrsf_pkg::IDX_W-1:0]       range_last,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mrsf_pkg::IDX_W-1:0]       split_index
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = mrsf_pkg::IDX_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_RDLAST = 5'b00010,
        ST_SETUP  = 5'b00100,
        ST_SEARCH = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [IW-1:0]        first_reg, first_next;
    logic [IW-1:0]        last_reg, last_next;
    logic [IW-1:0]        result_reg, result_next;
    logic [IW-1:0]        step_reg, step_next;
    logic [IW:0]          probe_reg, probe_next;
    logic                 probe_ok_reg, probe_ok_next;
    logic                 rd_ok_reg, rd_ok_next;
    logic [CODE_BITS-1:0] fcode_reg, fcode_next;
    logic [CODE_BITS-1:0] xl_reg, xl_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IW-1:0]        split_reg, split_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [CODE_BITS-1:0] ram_rdata;
    logic [IW:0]          addr_sel;
    logic [CODE_BITS-1:0] rd_code;
    logic [CODE_BITS-1:0] x_probe;
    logic                 hit;
    logic [IW-1:0]        res_sel;
    logic [IW:0]          step_half;
    logic [IW:0]          sum_ends;
    logic [IW-1:0]        span;
    logic                 in_accept;

    function automatic logic in_table(logic [IW:0] idx);
        return 32'(idx) < TABLE_DEPTH;
    endfunction

    mrsf_ram #(
        .WIDTH (CODE_BITS),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (load_code[CODE_BITS-1:0]),
        .rdata (ram_rdata)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign split_index = split_reg;
    assign rd_code     = rd_ok_reg ? ram_rdata : '0;
    assign ram_addr    = AW'(addr_sel);

    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        result_next    = result_reg;
        step_next      = step_reg;
        probe_next     = probe_reg;
        probe_ok_next  = probe_ok_reg;
        fcode_next     = fcode_reg;
        xl_next        = xl_reg;
        out_valid_next = out_valid_reg;
        split_next     = split_reg;
        ram_we         = 1'b0;
        addr_sel       = '0;
        step_half      = '0;
        sum_ends       = '0;
        span           = '0;
        x_probe        = '0;
        hit            = 1'b0;
        res_sel        = result_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (mode == mrsf_pkg::MODE_LOAD)
                    begin
                        addr_sel = {1'b0, load_index};
                        ram_we   = in_table({1'b0, load_index});
                    end
                    else
                    begin
                        addr_sel   = {1'b0, range_first};
                        first_next = range_first;
                        last_next  = range_last;
                        state_next = ST_RDLAST;
                    end
                end
            end
            ST_RDLAST:
            begin
                fcode_next = rd_code;
                addr_sel   = {1'b0, last_reg};
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                result_next = first_reg;
                if (fcode_reg == rd_code)
                begin
                    sum_ends    = {1'b0, first_reg} + {1'b0, last_reg};
                    result_next = sum_ends[IW:1];
                    state_next  = ST_DONE;
                end
                else if (first_reg < last_reg)
                begin
                    xl_next       = fcode_reg ^ rd_code;
                    span          = last_reg - first_reg;
                    step_half     = ({1'b0, span} + 1'b1) >> 1;
                    step_next     = step_half[IW-1:0];
                    probe_next    = {1'b0, first_reg} + step_half;
                    probe_ok_next = probe_next < {1'b0, last_reg};
                    addr_sel      = probe_next;
                    state_next    = ST_SEARCH;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SEARCH:
            begin
                // msb(x) below msb(xl) means a longer common prefix
                x_probe     = fcode_reg ^ rd_code;
                hit         = probe_ok_reg && (x_probe < xl_reg)
                              && (x_probe < (x_probe ^ xl_reg));
                res_sel     = hit ? probe_reg[IW-1:0] : result_reg;
                result_next = res_sel;
                if (step_reg > IW'(1))
                begin
                    step_half     = ({1'b0, step_reg} + 1'b1) >> 1;
                    step_next     = step_half[IW-1:0];
                    probe_next    = {1'b0, res_sel} + step_half;
                    probe_ok_next = probe_next < {1'b0, last_reg};
                    addr_sel      = probe_next;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    split_next     = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rd_ok_next = in_table(addr_sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg    <= first_next;
        last_reg     <= last_next;
        result_reg   <= result_next;
        step_reg     <= step_next;
        probe_reg    <= probe_next;
        probe_ok_reg <= probe_ok_next;
        rd_ok_reg    <= rd_ok_next;
        fcode_reg    <= fcode_next;
        xl_reg       <= xl_next;
        split_reg    <= split_next;
    end

endmodule

>>> hw/rtl/mrsf_ram.sv
// ----------------------------------------------------------------------------
// mrsf_ram
// generic single-port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module mrsf_ram #(
    parameter int WIDTH = mrsf_pkg::CODE_BITS_DEF,
    parameter int DEPTH = mrsf_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> hw/rtl/mrsf_checker.sv
// ----------------------------------------------------------------------------
// mrsf_checker
// port-level checks on the split finder transactions
// ----------------------------------------------------------------------------
module mrsf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       mode,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [mrsf_pkg::IDX_W-1:0] split_index
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(split_index))
        else $error("stalled result changed");

    // a query occupies the block
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (mode == mrsf_pkg::MODE_FIND) |=> in_stall)
        else $error("query transaction did not block input");

    // a load does not block the input
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (mode == mrsf_pkg::MODE_LOAD) |=> !in_stall)
        else $error("load transaction blocked input");

    // results only come out of a running query
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without query in flight");

endmodule

bind morton_range_split_finder_core mrsf_checker u_mrsf_checker (.*);

>>> bench/morton_range_split_finder_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// morton_range_split_finder_core_tb
// fills the code table with sorted segments and queries split positions over
// written ranges; each split_index is checked against a known value or a split search
// model kept in the bench, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module morton_range_split_finder_core_tb;

    localparam int IDX_W           = mrsf_pkg::IDX_W;
    localparam int FIELD_CODE_W    = mrsf_pkg::FIELD_CODE_W;
    localparam int TABLE_DEPTH_DEF = mrsf_pkg::TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS    = 750;
    localparam int LONG_HOLD       = 300;
    localparam int TAIL_CYCLES     = 20;
    localparam int PENDING_DEPTH   = 16;
    localparam int LAST_IDX        = TABLE_DEPTH_DEF - 1;
    localparam logic [FIELD_CODE_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic                    mode;
        logic [IDX_W-1:0]        index;
        logic [FIELD_CODE_W-1:0] code;
        logic [IDX_W-1:0]        rng_first;
        logic [IDX_W-1:0]        rng_last;
        logic                    known;
        logic [IDX_W-1:0]        known_split;
    } stim_row_t;

    logic                    clk;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_stall;
    logic                    mode        = mrsf_pkg::MODE_LOAD;
    logic [IDX_W-1:0]        load_index  = '0;
    logic [FIELD_CODE_W-1:0] load_code   = '0;
    logic [IDX_W-1:0]        range_first = '0;
    logic [IDX_W-1:0]        range_last  = '0;
    logic                    out_valid;
    logic                    out_stall   = 1'b0;
    logic [IDX_W-1:0]        split_index;

    logic [FIELD_CODE_W-1:0] code_mirror [TABLE_DEPTH_DEF];
    bit                      loaded [TABLE_DEPTH_DEF];
    logic [IDX_W-1:0]        pending_splits [PENDING_DEPTH];
    int unsigned             pend_wr        = 0;
    int unsigned             pend_rd        = 0;
    int                      mismatch_count = 0;
    int unsigned             item_count     = 0;
    bit                      burst_mode     = 1'b0;
    bit                      long_hold_req  = 1'b0;

    morton_range_split_finder_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .load_index  (load_index),
        .load_code   (load_code),
        .range_first (range_first),
        .range_last  (range_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .split_index (split_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned lead_zeros(logic [FIELD_CODE_W-1:0] x);
        int unsigned n;
        n = 0;
        for (int b = FIELD_CODE_W - 1; b >= 0; b--)
        begin
            if (x[b])
                break;
            n++;
        end
        return n;
    endfunction

    function automatic logic [IDX_W-1:0] predict_split(logic [IDX_W-1:0] rf, logic [IDX_W-1:0] rl);
        logic [FIELD_CODE_W-1:0] first_code;
        logic [FIELD_CODE_W-1:0] last_code;
        int unsigned             f;
        int unsigned             l;
        int unsigned             res;
        int unsigned             step;
        int unsigned             probe;
        int unsigned             common;
        f          = rf;
        l          = rl;
        first_code = code_mirror[f];
        last_code  = code_mirror[l];
        res        = f;
        if (first_code == last_code)
            res = (f + l) >> 1;
        else if (f < l)
        begin
            common = lead_zeros(first_code ^ last_code);
            step   = l - f;
            do
            begin
                step  = (step + 1) >> 1;
                probe = res + step;
                if (probe < l && lead_zeros(first_code ^ code_mirror[probe]) > common)
                    res = probe;
            end
            while (step > 1);
        end
        return res[IDX_W-1:0];
    endfunction

    function automatic stim_row_t load_row(int unsigned idx, logic [FIELD_CODE_W-1:0] code);
        stim_row_t row;
        row.mode        = mrsf_pkg::MODE_LOAD;
        row.index       = idx[IDX_W-1:0];
        row.code        = code;
        row.rng_first   = IDX_W'($urandom_range(0, LAST_IDX));
        row.rng_last    = IDX_W'($urandom_range(0, LAST_IDX));
        row.known       = 1'b0;
        row.known_split = '0;
        return row;
    endfunction

    function automatic stim_row_t find_row(int unsigned rf, int unsigned rl);
        stim_row_t row;
        row.mode        = mrsf_pkg::MODE_FIND;
        row.index       = IDX_W'($urandom_range(0, LAST_IDX));
        row.code        = {$urandom, $urandom};
        row.rng_first   = rf[IDX_W-1:0];
        row.rng_last    = rl[IDX_W-1:0];
        row.known       = 1'b0;
        row.known_split = '0;
        return row;
    endfunction

    function automatic stim_row_t known_row(int unsigned rf, int unsigned rl, int unsigned split);
        stim_row_t row;
        row             = find_row(rf, rl);
        row.known       = 1'b1;
        row.known_split = split[IDX_W-1:0];
        return row;
    endfunction

    function automatic int unsigned pick_loaded();
        int unsigned idx;
        do
        begin
            idx = $urandom_range(0, LAST_IDX);
        end
        while (!loaded[idx]);
        return idx;
    endfunction

    function automatic int unsigned pending_count();
        return pend_wr - pend_rd;
    endfunction

    task automatic add_pending(logic [IDX_W-1:0] want);
        pending_splits[pend_wr % PENDING_DEPTH] = want;
        pend_wr++;
    endtask

    task automatic report_mismatch(string note, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
        $display("%0t mismatch (%s): expected %0d got %0d", $time, note, want, got);
        mismatch_count++;
    endtask

    task automatic drive_item(input stim_row_t row);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= row.mode;
        load_index  <= row.index;
        load_code   <= row.code;
        range_first <= row.rng_first;
        range_last  <= row.rng_last;
        do
        begin
            @(posedge clk);
        end
        while (in_stall !== 1'b0);
        if (row.mode == mrsf_pkg::MODE_LOAD)
        begin
            code_mirror[row.index] = row.code;
            loaded[row.index]      = 1'b1;
        end
        else if (row.known)
            add_pending(row.known_split);
        else
            add_pending(predict_split(row.rng_first, row.rng_last));
        item_count++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count() != 0)
            @(posedge clk);
    endtask

    // result side
    initial
    begin : result_side
        int unsigned      gap;
        logic [IDX_W-1:0] want;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold_req)
            begin
                gap           = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else
                gap = burst_mode ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (out_valid !== 1'b1);
            if (pending_count() == 0)
                report_mismatch("no query pending", '0, split_index);
            else
            begin
                want = pending_splits[pend_rd % PENDING_DEPTH];
                pend_rd++;
                if (split_index !== want)
                    report_mismatch("split_index", want, split_index);
            end
        end
    end

    initial
    begin : watchdog
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t               directed_rows [22];
        int unsigned             phase;
        int unsigned             len;
        int unsigned             base;
        int unsigned             width_k;
        int unsigned             pick;
        int unsigned             nq;
        int unsigned             first_idx;
        int unsigned             stop_idx;
        int unsigned             random_start;
        int unsigned             pa;
        int unsigned             pb;
        logic [FIELD_CODE_W-1:0] mask;
        logic [FIELD_CODE_W-1:0] prefix;
        logic [FIELD_CODE_W-1:0] acc;
        bit                      flat;

        directed_rows = '{
            load_row(0, 64'd0),
            load_row(1, 64'd0),
            load_row(2, 64'd1),
            load_row(3, 64'h0000_0000_0000_00FF),
            load_row(4, 64'h7FFF_FFFF_FFFF_FFFF),
            load_row(5, 64'h8000_0000_0000_0000),
            load_row(6, 64'hFFFF_FFFF_FFFF_FFFE),
            load_row(7, ALL_ONES),
            load_row(LAST_IDX - 2, ALL_ONES),
            load_row(LAST_IDX - 1, ALL_ONES),
            load_row(LAST_IDX, ALL_ONES),
            // single-entry ranges
            known_row(0, 0, 0),
            known_row(LAST_IDX, LAST_IDX, LAST_IDX),
            // equal end codes give the midpoint
            known_row(0, 1, 0),
            known_row(LAST_IDX - 2, LAST_IDX, LAST_IDX - 1),
            // inverted ranges
            known_row(LAST_IDX, 7, (LAST_IDX + 7) >> 1),
            known_row(7, 0, 7),
            known_row(LAST_IDX - 1, 5, LAST_IDX - 1),
            // adjacent codes that differ
            known_row(6, 7, 6),
            find_row(0, 7),
            find_row(2, 6),
            find_row(3, 5)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            drive_item(directed_rows[i]);
        drain_results();

        phase        = 0;
        random_start = item_count;
        while (item_count - random_start < RANDOM_ITEMS)
        begin
            phase++;
            burst_mode = ($urandom_range(0, 3) == 0);
            if (phase == 4 || phase == 25)
                long_hold_req = 1'b1;

            // sorted segment with a shared prefix above width_k bits
            len     = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(2, 24);
            base    = $urandom_range(0, TABLE_DEPTH_DEF - len);
            width_k = $urandom_range(1, FIELD_CODE_W);
            mask    = (width_k == FIELD_CODE_W) ? ALL_ONES : ((64'd1 << width_k) - 1);
            prefix  = {$urandom, $urandom};
            acc     = ({$urandom, $urandom} & mask) >> 2;
            flat    = ($urandom_range(0, 7) == 0);
            for (int j = 0; j < len; j++)
            begin
                pick = flat ? 0 : $urandom_range(0, 3);
                if (pick == 1)
                    acc = acc + 1;
                else if (pick >= 2)
                    acc = acc + (64'd1 << $urandom_range(0, (width_k > 6) ? width_k - 6 : 0));
                drive_item(load_row(base + j, (prefix & ~mask) | (acc & mask)));
            end

            nq = $urandom_range(4, 12);
            for (int q = 0; q < nq; q++)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    drive_item(load_row($urandom_range(0, LAST_IDX), {$urandom, $urandom}));
                else if (pick == 1)
                begin
                    // inverted or single-entry range reads only its two ends
                    pa = pick_loaded();
                    pb = pick_loaded();
                    drive_item(find_row((pa > pb) ? pa : pb, (pa > pb) ? pb : pa));
                end
                else
                begin
                    // stay inside a fully written run
                    first_idx = $urandom_range(base, base + len - 1);
                    stop_idx  = first_idx;
                    while (stop_idx < LAST_IDX && loaded[stop_idx + 1])
                        stop_idx++;
                    drive_item(find_row(first_idx, $urandom_range(first_idx, stop_idx)));
                end
            end

            if (phase % 6 == 0)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
